// ----- rtl/core/erwf_pkg.sv -----
// shared types and constants of the extreme-replacing window filter
package erwf_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int DIGIT_W        = 4;
    localparam int DIGITS_PER_CYC = 3;
    localparam int CHUNK_W        = DIGIT_W * DIGITS_PER_CYC;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } erwf_state_t;

    typedef struct packed {
        logic load_sample;
        logic decide;
        logic update;
        logic div_step;
        logic out_load;
    } erwf_cmd_t;

    typedef struct packed {
        logic div_done;
    } erwf_status_t;

endpackage

// ----- rtl/core/erwf_ctrl.sv -----
// sequencing state machine and output valid of the window filter
module erwf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  erwf_pkg::erwf_status_t status,
    output erwf_pkg::erwf_cmd_t    cmd
);
    import erwf_pkg::*;

    erwf_state_t state_reg;
    erwf_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/erwf_dpath.sv -----
// sorted window, running sum, extreme choice and radix-16 divider
module erwf_dpath #(
    parameter int WINDOW = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  erwf_pkg::erwf_cmd_t             cmd,
    output erwf_pkg::erwf_status_t          status,
    input  logic [erwf_pkg::SAMPLE_W-1:0]   sample,
    output logic [erwf_pkg::SAMPLE_W-1:0]   average,
    output logic                            accepted,
    output logic                            ready_res
);
    import erwf_pkg::*;

    localparam int SUMW  = SAMPLE_W + $clog2(WINDOW);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int LHSW  = SAMPLE_W + 1 + $clog2(WINDOW + 1);
    localparam int NDIG  = (SUMW + DIGIT_W - 1) / DIGIT_W;
    localparam int NCYC  = (NDIG + DIGITS_PER_CYC - 1) / DIGITS_PER_CYC;
    localparam int PADW  = NCYC * CHUNK_W;
    localparam int CNTW  = $clog2(NCYC + 1);
    localparam int RW    = $clog2(WINDOW);
    localparam int VW    = RW + DIGIT_W;

    logic [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [SUMW-1:0]     sum_reg;
    logic [FW-1:0]       fill_reg;
    logic [SAMPLE_W-1:0] samp_reg;
    logic                hit_reg;
    logic                rmax_reg;
    logic                filling_reg;
    logic [SAMPLE_W-1:0] ext_reg;
    logic                acc_res_reg;
    logic                rdy_res_reg;
    logic [PADW-1:0]     num_reg;
    logic [RW-1:0]       rem_reg;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic [SAMPLE_W-1:0] average_reg;
    logic                accepted_reg;
    logic                ready_res_reg;

    // decision on the held extremes
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic                filling;
    logic                in_rng;
    logic [LHSW-1:0]     lhs;
    logic [LHSW-1:0]     rhs;

    assign lo      = win_reg[0];
    assign hi      = win_reg[WINDOW-1];
    assign filling = (fill_reg != FW'(WINDOW));
    assign in_rng  = (samp_reg >= lo) && (samp_reg <= hi);
    assign lhs     = LHSW'({1'b0, hi} + {1'b0, lo}) * LHSW'(WINDOW);
    assign rhs     = LHSW'({sum_reg, 1'b0});

    // sorted insertion, on a base that drops the minimum when it is replaced
    logic                shift_down;
    logic [FW-1:0]       ins_len;
    logic [SAMPLE_W-1:0] base [WINDOW];
    logic [SAMPLE_W-1:0] ins  [WINDOW];
    logic [WINDOW-1:0]   gt;

    assign shift_down = !filling_reg && !rmax_reg;
    assign ins_len    = filling_reg ? fill_reg : FW'(WINDOW - 1);

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_ins
        if (i < WINDOW - 1)
        begin : g_base
            assign base[i] = shift_down ? win_reg[i+1] : win_reg[i];
        end
        else
        begin : g_last
            assign base[i] = win_reg[i];
        end

        assign gt[i] = (FW'(i) >= ins_len) || (base[i] > samp_reg);

        if (i == 0)
        begin : g_first
            assign ins[i] = gt[i] ? samp_reg : base[i];
        end
        else
        begin : g_rest
            assign ins[i] = !gt[i] ? base[i] : (!gt[i-1] ? samp_reg : base[i-1]);
        end
    end

    logic [SUMW-1:0] sum_upd;
    logic [SUMW-1:0] sum_after;

    assign sum_upd   = filling_reg ? (sum_reg + SUMW'(samp_reg))
                                   : (sum_reg - SUMW'(ext_reg) + SUMW'(samp_reg));
    assign sum_after = hit_reg ? sum_upd : sum_reg;

    // division by the window length, three radix-16 digits a cycle
    function automatic logic [DIGIT_W-1:0] qdigit(input logic [VW-1:0] v);
        logic [DIGIT_W-1:0] q;
        q = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++)
        begin
            if (v >= VW'(k * WINDOW))
            begin
                q = q + DIGIT_W'(1);
            end
        end
        return q;
    endfunction

    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_W-1:0] qd;
    logic [RW-1:0]      rem_out;

    assign chunk = num_reg[PADW-1 -: CHUNK_W];

    always_comb
    begin
        logic [VW-1:0]      val_s;
        logic [DIGIT_W-1:0] q_s;
        logic [RW-1:0]      r_s;
        r_s = rem_reg;
        qd  = '0;
        for (int j = 0; j < DIGITS_PER_CYC; j++)
        begin
            val_s = {r_s, chunk[CHUNK_W-1-j*DIGIT_W -: DIGIT_W]};
            q_s   = qdigit(val_s);
            r_s   = RW'(val_s - VW'(q_s) * VW'(WINDOW));
            qd[CHUNK_W-1-j*DIGIT_W -: DIGIT_W] = q_s;
        end
        rem_out = r_s;
    end

    assign status.div_done = (cnt_reg == CNTW'(NCYC - 1));

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg  <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.update && hit_reg)
            begin
                for (int i = 0; i < WINDOW; i++)
                begin
                    win_reg[i] <= ins[i];
                end
                sum_reg <= sum_upd;
                if (filling_reg)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (cmd.update)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            samp_reg <= sample;
        end
        if (cmd.decide)
        begin
            hit_reg     <= filling || in_rng;
            rmax_reg    <= (lhs > rhs);
            filling_reg <= filling;
            ext_reg     <= (lhs > rhs) ? hi : lo;
        end
        if (cmd.update)
        begin
            acc_res_reg <= hit_reg;
            rdy_res_reg <= !filling_reg || (fill_reg == FW'(WINDOW - 1));
            num_reg     <= PADW'(sum_after);
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << CHUNK_W;
            rem_reg <= rem_out;
            quo_reg <= SAMPLE_W'({quo_reg, qd});
        end
        if (cmd.out_load)
        begin
            average_reg   <= rdy_res_reg ? quo_reg : '0;
            accepted_reg  <= acc_res_reg;
            ready_res_reg <= rdy_res_reg;
        end
    end

    assign average   = average_reg;
    assign accepted  = accepted_reg;
    assign ready_res = ready_res_reg;

endmodule

// ----- rtl/core/extreme_replacing_window_filter_unit.sv -----
// top level of the extreme-replacing window filter
//
// Keeps a sorted window of WINDOW unsigned Q24.8 frequency samples and their
// exact sum. The first WINDOW transactions fill the window and report a zero
// average with ready_res low until the transaction that completes it. After
// that, a sample outside [min, max] is rejected (accepted = 0, average repeats),
// and a sample inside replaces whichever extreme lies farther from the exact
// average (the maximum when WINDOW*(max+min) > 2*sum, else the minimum). Every
// input transaction gives exactly one output transaction. An item occupies the
// block through these steps in order: the accept cycle that captures the
// sample, the extreme decision, sorted insertion with sum update, the steps
// of the radix-16 divider that forms sum/WINDOW, and the output register
// load. A new input is taken as soon as, and not before, the result sits in
// the output register, even while the output transaction waits for
// out_ready; the load itself waits only if the previous result has not been
// taken yet.
module extreme_replacing_window_filter_unit #(
    parameter int WINDOW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [erwf_pkg::SAMPLE_W-1:0] sample,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [erwf_pkg::SAMPLE_W-1:0] average,
    output logic                          accepted,
    output logic                          ready_res
);
    import erwf_pkg::*;

    // command and status between sequencer and datapath
    erwf_cmd_t    cmd;
    erwf_status_t status;

    // sequencer: one transaction in flight, output valid kept here
    erwf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // window, sum, divider and output payload registers
    erwf_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .average   (average),
        .accepted  (accepted),
        .ready_res (ready_res)
    );

endmodule

// ----- rtl/core/erwf_checker.sv -----
// port-level checks of the window filter and their binding
module erwf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] average,
    input logic        accepted,
    input logic        ready_res
);
    logic seen_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_full_reg <= 1'b0;
        end
        else if (out_valid && out_ready && ready_res)
        begin
            seen_full_reg <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average)
            && $stable(accepted) && $stable(ready_res))
        else $error("output changed while stalled");

    // while filling every sample enters and the average is zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ready_res |-> accepted && (average == 32'd0))
        else $error("filling result not accepted or nonzero average");

    // once full, the window stays full
    a_stay_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_full_reg |-> ready_res)
        else $error("ready_res dropped after window was full");

    // one item at a time: no input transaction right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind extreme_replacing_window_filter_unit erwf_checker u_erwf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .average   (average),
    .accepted  (accepted),
    .ready_res (ready_res)
);
